@@ rtl/cbv_pkg.sv @@
// ----------------------------------------------------------------------------
// cbv_pkg
// Shared types and constants for the CBOR stream validator: channel words,
// the decoded byte that travels through the queue, and the code points used
// by the front and back parts.
// ----------------------------------------------------------------------------
package cbv_pkg;

    // Input word: one byte of the buffer and its end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic       valid_res;
        logic [4:0] nesting_depth;
    } t_out_word;

    // Status codes
    localparam logic [1:0] STAT_OPEN  = 2'd0;
    localparam logic [1:0] STAT_DONE  = 2'd1;
    localparam logic [1:0] STAT_ERROR = 2'd2;

    // Major types that need handling of their own
    localparam logic [2:0] MAJ_BSTR   = 3'd2;
    localparam logic [2:0] MAJ_TSTR   = 3'd3;
    localparam logic [2:0] MAJ_ARRAY  = 3'd4;
    localparam logic [2:0] MAJ_MAP    = 3'd5;
    localparam logic [2:0] MAJ_TAG    = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    // Additional info bounds
    localparam logic [4:0] INFO_MASK   = 5'h1F;
    localparam logic [4:0] INFO_EXT_LO = 5'd24;
    localparam logic [4:0] INFO_EXT_HI = 5'd27;

    // Head byte class, as seen by the front part
    typedef enum logic [1:0] {
        KIND_IMM    = 2'd0,   // argument held in the head itself
        KIND_EXT    = 2'd1,   // argument follows in 1, 2, 4 or 8 bytes
        KIND_SIMPLE = 2'd2,   // reserved info on a simple value: complete
        KIND_BAD    = 2'd3    // reserved info elsewhere: error
    } t_kind;

    // Queue entry: raw byte plus its head decode
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [2:0] major;
        logic [4:0] info;
        t_kind      kind;
        logic [3:0] ext_bytes;
    } t_dec;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One open level: items still needed, as remaining * 2 + map_half
    typedef struct packed {
        logic [63:0] remaining;
        logic        map_half;
    } t_level;

endpackage

@@ rtl/cbor_stream_validator.sv @@
// ----------------------------------------------------------------------------
// cbor_stream_validator
// Checks, one byte per word, that a buffer holds exactly one well-formed
// CBOR data item, with nesting kept on a stack of MAX_DEPTH levels.
//
//   channel  direction  handshake                  word
//   in       input      i_in_valid / o_in_ready    i_in_data  (t_in_word)
//   out      output     o_out_valid / i_out_ready  o_out_data (t_out_word)
//
// A byte passes the back part through execute and result when it completes
// no item; a completed item adds, for each stack level it touches, a read of
// the stack memory and an update or pop of the level, plus a further stack
// check when it completes the top-level item.
// The front accepts bytes into a 2-word queue while the back works.
// Reset is synchronous; the stack memory needs no clearing pass.
// A stalled output holds its word and the back part waits, the queue fills.
// ----------------------------------------------------------------------------
module cbor_stream_validator
    import cbv_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic q_push;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    t_dec front_entry;
    t_dec q_entry;

    // Classify incoming bytes
    cbv_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (q_push),
        .i_q_ready  (q_ready),
        .o_entry    (front_entry)
    );

    // Buffer decoded bytes
    cbv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    // Execute and report
    cbv_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/cbv_front.sv @@
// ----------------------------------------------------------------------------
// cbv_front
// Accepts input words and classifies each byte as a head: major type,
// additional info, argument class and length of the extended argument.
// ----------------------------------------------------------------------------
module cbv_front
    import cbv_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_data,
    output logic     o_push,
    input  logic     i_q_ready,
    output t_dec     o_entry
);

    logic [4:0] info;
    logic [2:0] major;

    assign major = i_in_data.data_byte[7:5];
    assign info  = i_in_data.data_byte[4:0] & INFO_MASK;

    // Accept whenever the queue has room
    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready;

    // Classify the byte as a head; the back part decides whether it is one
    always_comb begin
        o_entry.data_byte = i_in_data.data_byte;
        o_entry.last_byte = i_in_data.last_byte;
        o_entry.major     = major;
        o_entry.info      = info;
        o_entry.ext_bytes = 4'd1 << info[1:0];
        priority if (info < INFO_EXT_LO) begin
            o_entry.kind = KIND_IMM;
        end else if (info <= INFO_EXT_HI) begin
            o_entry.kind = KIND_EXT;
        end else if (major == MAJ_SIMPLE) begin
            o_entry.kind = KIND_SIMPLE;
        end else begin
            o_entry.kind = KIND_BAD;
        end
    end

endmodule

@@ rtl/cbv_queue.sv @@
// ----------------------------------------------------------------------------
// cbv_queue
// Short queue of decoded bytes between the front and the back part.
// ----------------------------------------------------------------------------
module cbv_queue
    import cbv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_dec i_entry,
    output logic o_ready,
    output logic o_valid,
    input  logic i_pop,
    output t_dec o_entry
);

    localparam logic [Q_AW-1:0] PTR_LAST = Q_AW'(Q_DEPTH - 1);
    localparam logic [Q_CW-1:0] CNT_FULL = Q_CW'(Q_DEPTH);

    t_dec            r_buf [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_buf[r_rp];

    // Store the word at the write pointer
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/cbv_back.sv @@
// ----------------------------------------------------------------------------
// cbv_back
// Carries out one decoded byte at a time: gathers extended arguments, skips
// string payloads, opens levels on the nesting stack and closes finished
// levels one per pass through the stack memory, then registers the result.
// ----------------------------------------------------------------------------
module cbv_back
    import cbv_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_dec      i_q_entry,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int SW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DW = (SW < 5) ? SW : 5;
    localparam logic [SW-1:0] TOP_MAX = SW'(MAX_DEPTH);

    typedef enum logic [3:0] {
        BK_EXEC = 4'b0001,   // take a word from the queue and act on it
        BK_CRD  = 4'b0010,   // read the top level after a completed item
        BK_CUP  = 4'b0100,   // count the item against the top level
        BK_FIN  = 4'b1000    // form the result word
    } t_bk_state;

    // Control state
    t_bk_state   r_state, n_state;
    logic [SW-1:0] r_top, n_top;
    logic [2:0]  r_head_major, n_head_major;
    logic [3:0]  r_arg_left, n_arg_left;
    logic [63:0] r_arg, n_arg;
    logic [63:0] r_str_left, n_str_left;
    logic        r_item_done, n_item_done;
    logic        r_err, n_err;
    logic        r_out_valid, n_out_valid;

    // Payload state
    logic        r_done_now, n_done_now;
    logic        r_last, n_last;
    t_out_word   r_out_data, n_out_data;

    // Stack memory
    t_level      r_mem [MAX_DEPTH];
    t_level      r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_level        mem_wd;
    logic [SW-1:0] top_m1;
    logic [AW-1:0] rd_addr;

    // Decode helpers
    logic [63:0] arg_shift;
    logic        head_fin;
    logic [2:0]  fh_major;
    logic [63:0] fh_arg;
    logic        go_cpl;
    logic        do_open;
    t_level      open_lvl;
    logic        err_f;

    assign top_m1    = r_top - 1'b1;
    assign rd_addr   = top_m1[AW-1:0];
    assign arg_shift = {r_arg[55:0], i_q_entry.data_byte};

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Stack memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_head_major = r_head_major;
        n_arg_left   = r_arg_left;
        n_arg        = r_arg;
        n_str_left   = r_str_left;
        n_item_done  = r_item_done;
        n_err        = r_err;
        n_done_now   = r_done_now;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        mem_we       = 1'b0;
        mem_wa       = rd_addr;
        mem_wd       = '0;
        o_q_pop      = 1'b0;
        head_fin     = 1'b0;
        fh_major     = r_head_major;
        fh_arg       = arg_shift;
        go_cpl       = 1'b0;
        do_open      = 1'b0;
        open_lvl     = '0;
        err_f        = r_err || (r_last && !r_item_done);

        unique case (r_state)
            BK_EXEC: begin
                if (i_q_valid) begin
                    o_q_pop    = 1'b1;
                    n_last     = i_q_entry.last_byte;
                    n_done_now = 1'b0;
                    n_state    = BK_FIN;
                    priority if (r_err) begin
                        // drop bytes until the end of the buffer
                    end else if (r_item_done) begin
                        n_err = 1'b1;
                    end else if (r_arg_left != '0) begin
                        n_arg      = arg_shift;
                        n_arg_left = r_arg_left - 1'b1;
                        if (r_arg_left == 4'd1) begin
                            head_fin = 1'b1;
                            fh_major = r_head_major;
                            fh_arg   = arg_shift;
                        end
                    end else if (r_str_left != '0) begin
                        n_str_left = r_str_left - 1'b1;
                        if (r_str_left == 64'd1) begin
                            go_cpl = 1'b1;
                        end
                    end else begin
                        n_head_major = i_q_entry.major;
                        unique case (i_q_entry.kind)
                            KIND_IMM: begin
                                head_fin = 1'b1;
                                fh_major = i_q_entry.major;
                                fh_arg   = 64'(i_q_entry.info);
                            end
                            KIND_EXT: begin
                                n_arg_left = i_q_entry.ext_bytes;
                                n_arg      = '0;
                            end
                            KIND_SIMPLE: go_cpl = 1'b1;
                            KIND_BAD:    n_err  = 1'b1;
                        endcase
                    end

                    // Act on a finished head
                    if (head_fin) begin
                        unique case (fh_major)
                            MAJ_BSTR, MAJ_TSTR: begin
                                if (fh_arg == '0) begin
                                    go_cpl = 1'b1;
                                end else begin
                                    n_str_left = fh_arg;
                                end
                            end
                            MAJ_ARRAY: begin
                                if (fh_arg == '0) begin
                                    go_cpl = 1'b1;
                                end else begin
                                    do_open  = 1'b1;
                                    open_lvl = '{remaining: {1'b0, fh_arg[63:1]},
                                                 map_half: fh_arg[0]};
                                end
                            end
                            MAJ_MAP: begin
                                if (fh_arg == '0) begin
                                    go_cpl = 1'b1;
                                end else begin
                                    do_open  = 1'b1;
                                    open_lvl = '{remaining: fh_arg, map_half: 1'b0};
                                end
                            end
                            MAJ_TAG: begin
                                do_open  = 1'b1;
                                open_lvl = '{remaining: 64'd0, map_half: 1'b1};
                            end
                            default: go_cpl = 1'b1;
                        endcase
                    end

                    // Push a level, or flag the overflow
                    if (do_open) begin
                        if (r_top >= TOP_MAX) begin
                            n_err = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                            mem_wa = r_top[AW-1:0];
                            mem_wd = open_lvl;
                            n_top  = r_top + 1'b1;
                        end
                    end

                    if (go_cpl) begin
                        n_state = BK_CRD;
                    end
                end
            end

            BK_CRD: begin
                if (r_top == '0) begin
                    n_item_done = 1'b1;
                    n_done_now  = 1'b1;
                    n_state     = BK_FIN;
                end else begin
                    n_state = BK_CUP;
                end
            end

            BK_CUP: begin
                // Pop a level whose last item just arrived, else count it down
                if (r_rd_data.map_half && (r_rd_data.remaining == '0)) begin
                    n_top   = r_top - 1'b1;
                    n_state = BK_CRD;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = rd_addr;
                    if (r_rd_data.map_half) begin
                        mem_wd = '{remaining: r_rd_data.remaining, map_half: 1'b0};
                    end else begin
                        mem_wd = '{remaining: r_rd_data.remaining - 64'd1,
                                   map_half: 1'b1};
                    end
                    n_state = BK_FIN;
                end
            end

            BK_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data.status        = err_f ? STAT_ERROR :
                                               (r_done_now ? STAT_DONE : STAT_OPEN);
                    n_out_data.valid_res     = r_last && r_item_done && !err_f;
                    n_out_data.nesting_depth = 5'(r_top[DW-1:0]);
                    n_err   = err_f;
                    n_state = BK_EXEC;
                    // End of buffer: back to the reset state
                    if (r_last) begin
                        n_top        = '0;
                        n_head_major = '0;
                        n_arg_left   = '0;
                        n_arg        = '0;
                        n_str_left   = '0;
                        n_item_done  = 1'b0;
                        n_err        = 1'b0;
                    end
                end
            end

            default: n_state = BK_EXEC;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_EXEC;
            r_top        <= '0;
            r_head_major <= '0;
            r_arg_left   <= '0;
            r_arg        <= '0;
            r_str_left   <= '0;
            r_item_done  <= 1'b0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_top        <= n_top;
            r_head_major <= n_head_major;
            r_arg_left   <= n_arg_left;
            r_arg        <= n_arg;
            r_str_left   <= n_str_left;
            r_item_done  <= n_item_done;
            r_err        <= n_err;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_done_now <= n_done_now;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

endmodule

@@ rtl/cbv_checker.sv @@
// ----------------------------------------------------------------------------
// cbv_checker
// Port-level checks for the CBOR stream validator: result ordering against
// accepted words, bounded occupancy and consistency of a valid verdict.
// ----------------------------------------------------------------------------
module cbv_checker
    import cbv_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    logic       in_acc;
    logic       out_acc;
    logic [3:0] r_pend;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Count words accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {3'b0, in_acc} - {3'b0, out_acc};
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // No result without an accepted word
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 4'd0)
        else $error("result without a pending word");

    // Queue, back part and output register bound the words in flight
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'd4)
        else $error("too many words in flight");

    // A valid verdict completes the top-level item at that byte
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.valid_res |->
            i_out_data.status == STAT_DONE && i_out_data.nesting_depth == 5'd0)
        else $error("valid verdict without completed item");

endmodule

bind cbor_stream_validator cbv_checker u_cbv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

@@ verif/cbor_stream_validator_test.sv @@
// ----------------------------------------------------------------------------
// cbor_stream_validator_test
// Self-checking bench for the CBOR stream validator. Buffers of bytes are
// built up front: a directed set (reserved info, empty containers, trailing
// and missing bytes, full and overflowing nesting, 8-byte arguments), then
// random well-formed items mixed with broken and noise buffers. A clocked
// driver feeds them, a clocked monitor predicts each result word as the byte
// is accepted and compares it field by field with what the block returns.
// Sender gaps and receiver stalls change with the phase of the run, and one
// long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module cbor_stream_validator_test;
    import cbv_pkg::*;

    localparam int STACK_LEVELS = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 360;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    cbor_stream_validator #(.MAX_DEPTH(STACK_LEVELS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock and reset
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_in_word    pending[$];
    logic [7:0]  frame_q[$];
    t_out_word   pred_words[$];
    int          in_count    = 0;
    int          out_count   = 0;
    int          mismatches  = 0;
    int          buffers     = 0;
    int          good_bufs   = 0;
    int          err_words   = 0;
    int          total_bytes = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    int          quiet       = 0;

    // Predicted validator state
    logic [63:0] lvl_rem  [STACK_LEVELS];
    logic        lvl_half [STACK_LEVELS];
    int unsigned lvl_top   = 0;
    logic [2:0]  hd_major  = '0;
    int unsigned ext_left  = 0;
    logic [63:0] ext_val   = '0;
    logic [63:0] str_left  = '0;
    bit          top_done  = 1'b0;
    bit          bad       = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_validator();
        foreach (lvl_rem[i]) begin
            lvl_rem[i]  = '0;
            lvl_half[i] = 1'b0;
        end
        lvl_top  = 0;
        hd_major = '0;
        ext_left = 0;
        ext_val  = '0;
        str_left = '0;
        top_done = 1'b0;
        bad      = 1'b0;
    endfunction

    // Count one finished item against the open levels, popping full ones
    function automatic bit close_item();
        int t;
        while (lvl_top > 0) begin
            t = lvl_top - 1;
            if (lvl_half[t]) begin
                lvl_half[t] = 1'b0;
            end else begin
                lvl_rem[t]  = lvl_rem[t] - 64'd1;
                lvl_half[t] = 1'b1;
            end
            if (lvl_rem[t] != 64'd0 || lvl_half[t])
                return 1'b0;
            lvl_top--;
        end
        top_done = 1'b1;
        return 1'b1;
    endfunction

    function automatic void push_level(logic [63:0] hi, logic lo);
        if (lvl_top >= STACK_LEVELS) begin
            bad = 1'b1;
        end else begin
            lvl_rem[lvl_top]  = hi;
            lvl_half[lvl_top] = lo;
            lvl_top++;
        end
    endfunction

    function automatic bit act_on_head(logic [2:0] major, logic [63:0] arg);
        case (major)
            MAJ_BSTR, MAJ_TSTR: begin
                if (arg == 64'd0) return close_item();
                str_left = arg;
            end
            MAJ_ARRAY: begin
                if (arg == 64'd0) return close_item();
                push_level(arg >> 1, arg[0]);
            end
            MAJ_MAP: begin
                if (arg == 64'd0) return close_item();
                push_level(arg, 1'b0);
            end
            MAJ_TAG: push_level(64'd0, 1'b1);
            default: return close_item();
        endcase
        return 1'b0;
    endfunction

    function automatic t_out_word predict_word(t_in_word w);
        t_out_word  r;
        logic [2:0] maj;
        logic [4:0] info;
        bit         done_now;
        bit         ok;
        done_now = 1'b0;
        ok       = 1'b0;
        maj      = w.data_byte[7:5];
        info     = w.data_byte[4:0] & INFO_MASK;
        if (!bad) begin
            if (top_done) begin
                bad = 1'b1;
            end else if (ext_left > 0) begin
                ext_val = {ext_val[55:0], w.data_byte};
                ext_left--;
                if (ext_left == 0) done_now = act_on_head(hd_major, ext_val);
            end else if (str_left != 64'd0) begin
                str_left = str_left - 64'd1;
                if (str_left == 64'd0) done_now = close_item();
            end else begin
                hd_major = maj;
                if (info < INFO_EXT_LO) begin
                    done_now = act_on_head(maj, {59'd0, info});
                end else if (info <= INFO_EXT_HI) begin
                    ext_left = 1 << (info - INFO_EXT_LO);
                    ext_val  = '0;
                end else if (maj == MAJ_SIMPLE) begin
                    done_now = close_item();
                end else begin
                    bad = 1'b1;
                end
            end
        end
        if (w.last_byte) begin
            if (!top_done) bad = 1'b1;
            ok = top_done && !bad;
        end
        r.status        = bad ? STAT_ERROR : (done_now ? STAT_DONE : STAT_OPEN);
        r.valid_res     = ok;
        r.nesting_depth = lvl_top[4:0];
        if (w.last_byte) clear_validator();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Buffer builders
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand_arg();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return 64'($urandom_range(23));
        if (sel < 75) return 64'($urandom_range(255));
        if (sel < 90) return 64'($urandom_range(65535));
        if (sel < 95) return 64'($urandom);
        return {$urandom, $urandom};
    endfunction

    // Head with argument, sometimes in a wider form than needed
    function automatic void put_head(logic [2:0] major, logic [63:0] arg);
        int         nb;
        logic [4:0] info;
        if (arg < 64'd24 && $urandom_range(3) != 0) begin
            nb = 0;
        end else begin
            nb = (arg < 64'd256) ? 1 : (arg < 64'd65536) ? 2 :
                 (arg < 64'h1_0000_0000) ? 4 : 8;
            if ($urandom_range(3) == 0 && nb < 8) nb = nb * 2;
        end
        if (nb == 0) begin
            frame_q.push_back({major, arg[4:0]});
        end else begin
            case (nb)
                1:       info = INFO_EXT_LO;
                2:       info = INFO_EXT_LO + 5'd1;
                4:       info = INFO_EXT_LO + 5'd2;
                default: info = INFO_EXT_HI;
            endcase
            frame_q.push_back({major, info});
            for (int i = nb - 1; i >= 0; i--) frame_q.push_back(arg[8*i +: 8]);
        end
    endfunction

    // One random well-formed item, nesting kept within max_nest levels
    function automatic void put_item(int max_nest);
        int need[$];
        int kind;
        int n;
        int top;
        need.push_back(1);
        while (need.size() > 0) begin
            top = need.size() - 1;
            if (need[top] == 0) begin
                void'(need.pop_back());
                continue;
            end
            need[top] = need[top] - 1;
            kind = $urandom_range(9);
            if (need.size() > max_nest) kind = kind % 5;
            case (kind)
                0, 1: put_head(3'($urandom_range(1)), rand_arg());
                2, 4: begin
                    n = ($urandom_range(7) == 0) ? $urandom_range(20, 30)
                                                 : $urandom_range(6);
                    put_head($urandom_range(1) ? MAJ_TSTR : MAJ_BSTR, 64'(n));
                    repeat (n) frame_q.push_back(8'($urandom));
                end
                3: begin
                    if ($urandom_range(3) == 0)
                        frame_q.push_back({MAJ_SIMPLE, 5'($urandom_range(28, 31))});
                    else
                        put_head(MAJ_SIMPLE, rand_arg());
                end
                5, 6: begin
                    n = $urandom_range(3);
                    put_head(MAJ_ARRAY, 64'(n));
                    need.push_back(n);
                end
                7, 8: begin
                    n = $urandom_range(2);
                    put_head(MAJ_MAP, 64'(n));
                    need.push_back(2 * n);
                end
                default: begin
                    put_head(MAJ_TAG, rand_arg());
                    need.push_back(1);
                end
            endcase
        end
    endfunction

    // Move the built buffer into the send queue, marking its final byte
    function automatic int send_frame();
        int       n;
        t_in_word w;
        n = frame_q.size();
        foreach (frame_q[i]) begin
            w.data_byte = frame_q[i];
            w.last_byte = (i == n - 1);
            pending.push_back(w);
        end
        frame_q.delete();
        buffers++;
        return n;
    endfunction

    function automatic void put_bytes(logic [7:0] b, int n);
        repeat (n) frame_q.push_back(b);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int sel;
        int k;
        int sent;
        clear_validator();

        // Zero and the largest unsigned with an 8-byte argument
        frame_q.push_back({3'd0, 5'd0});
        void'(send_frame());
        frame_q.push_back({3'd0, INFO_EXT_HI});
        put_bytes(8'hFF, 8);
        void'(send_frame());
        // Negative with a one-byte argument, half-width simple value
        frame_q.push_back({3'd1, INFO_EXT_LO});
        frame_q.push_back(8'h00);
        void'(send_frame());
        frame_q.push_back({MAJ_SIMPLE, INFO_EXT_LO + 5'd1});
        frame_q.push_back(8'h7C);
        frame_q.push_back(8'h00);
        void'(send_frame());
        // Reserved info: accepted on simple values, an error elsewhere
        frame_q.push_back({MAJ_SIMPLE, 5'd31});
        void'(send_frame());
        frame_q.push_back({MAJ_TSTR, 5'd28});
        put_bytes({3'd0, 5'd0}, 2);
        void'(send_frame());
        frame_q.push_back({MAJ_TAG, 5'd30});
        void'(send_frame());
        // Empty string, bytes, array and map inside one array
        frame_q.push_back({MAJ_ARRAY, 5'd4});
        frame_q.push_back({MAJ_TSTR, 5'd0});
        frame_q.push_back({MAJ_BSTR, 5'd0});
        frame_q.push_back({MAJ_ARRAY, 5'd0});
        frame_q.push_back({MAJ_MAP, 5'd0});
        void'(send_frame());
        // Map of a text key to a tagged four-byte integer
        frame_q.push_back({MAJ_MAP, 5'd1});
        frame_q.push_back({MAJ_TSTR, 5'd2});
        frame_q.push_back(8'h61);
        frame_q.push_back(8'h62);
        frame_q.push_back({MAJ_TAG, 5'd1});
        frame_q.push_back({3'd0, INFO_EXT_LO + 5'd2});
        put_bytes(8'hA5, 4);
        void'(send_frame());
        // Trailing byte after a complete item, and an early end
        frame_q.push_back({3'd0, 5'd1});
        frame_q.push_back({3'd0, 5'd2});
        void'(send_frame());
        frame_q.push_back({MAJ_ARRAY, 5'd2});
        frame_q.push_back({3'd0, 5'd1});
        void'(send_frame());
        // Nesting exactly at the stack size, then one level past it
        put_bytes({MAJ_ARRAY, 5'd1}, STACK_LEVELS);
        frame_q.push_back({3'd0, 5'd0});
        void'(send_frame());
        put_bytes({MAJ_ARRAY, 5'd1}, STACK_LEVELS + 1);
        frame_q.push_back({3'd0, 5'd0});
        void'(send_frame());
        // Huge length and huge map count, cut short
        frame_q.push_back({MAJ_BSTR, INFO_EXT_HI});
        put_bytes(8'hFF, 8);
        frame_q.push_back(8'h00);
        void'(send_frame());
        frame_q.push_back({MAJ_MAP, INFO_EXT_HI});
        put_bytes(8'hFF, 8);
        frame_q.push_back({3'd0, 5'd0});
        void'(send_frame());

        // Random buffers: mostly well formed, the rest broken or noise
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            sel = $urandom_range(99);
            if (sel < 62) begin
                put_item((sel < 5) ? STACK_LEVELS : 4);
                sent += send_frame();
            end else if (sel < 70) begin
                put_item(3);
                repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
                sent += send_frame();
            end else if (sel < 78) begin
                put_item(4);
                k = $urandom_range(1, frame_q.size());
                while (frame_q.size() > k) void'(frame_q.pop_back());
                sent += send_frame();
            end else if (sel < 84) begin
                put_item(2);
                frame_q.insert($urandom_range(frame_q.size()),
                               {3'($urandom_range(6)), 5'($urandom_range(28, 31))});
                sent += send_frame();
            end else if (sel < 91) begin
                put_bytes({MAJ_ARRAY, 5'd1}, $urandom_range(13, STACK_LEVELS + 1));
                put_item(1);
                sent += send_frame();
            end else begin
                repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
                sent += send_frame();
            end
        end
        total_bytes = pending.size();

        // Drain, settle, then give the verdict
        wait (in_count == total_bytes);
        wait (pred_words.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Ran %0d bytes in %0d buffers, %0d judged well formed, %0d error words",
                 total_bytes, buffers, good_bufs, err_words);
        $display("Covered reserved info, empty items, overflow, trailing and early ends");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Idling profile by phase of the run
    // ------------------------------------------------------------------
    function automatic int idle_pct(bit rx_side);
        case ((in_count / 40) % 4)
            0:       return 0;
            1:       return rx_side ? 0 : 55;
            2:       return rx_side ? 55 : 0;
            default: return 16;
        endcase
    endfunction

    // Driver: offer the next byte, keep it stable until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending.size() > 0 &&
                (hold_left > 0 || $urandom_range(99) >= idle_pct(1'b0))) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && in_count >= 120) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_left > 0)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end

    task automatic report_mismatch(string field, int want, int got);
        mismatches++;
        if (mismatches <= 20)
            $display("MISMATCH word %0d %s: expected %0d, got %0d",
                     out_count, field, want, got);
    endtask

    // Monitor: predict on each accepted byte, check each accepted word
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pred_words.push_back(predict_word(i_in_data));
            in_count <= in_count + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_count <= out_count + 1;
            if (o_out_data.valid_res) good_bufs <= good_bufs + 1;
            if (o_out_data.status == STAT_ERROR) err_words <= err_words + 1;
            if (pred_words.size() == 0) begin
                report_mismatch("word with nothing expected", 0, int'(o_out_data));
            end else begin
                want = pred_words.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", want.status, o_out_data.status);
                if (o_out_data.valid_res !== want.valid_res)
                    report_mismatch("valid_res", want.valid_res, o_out_data.valid_res);
                if (o_out_data.nesting_depth !== want.nesting_depth)
                    report_mismatch("nesting_depth", want.nesting_depth,
                                    o_out_data.nesting_depth);
            end
        end
    end

    // Watchdog: stop when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: %0d words still expected", pred_words.size());
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
